@@ hw/rtl/luhn_card_number_classifier_assert.svh @@
// Assertion macros for the card number classifier.
// Used by the top level; requires clk_i and rst_ni in the including scope.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define LCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define LCC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LCC_ASSERT(lbl, prop, msg)
`define LCC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hw/rtl/lcc_pkg.sv @@
// Shared constants and helper functions for the card number classifier.
// No dependencies; imported by lcc_bin2bcd and luhn_card_number_classifier.
package lcc_pkg;

  // Input width and decimal conversion geometry.
  localparam int ValueWidth      = 63;
  localparam int DigitWidth      = 4;
  localparam int BcdDigits       = 19;
  localparam int BcdWidth        = BcdDigits * DigitWidth;
  localparam int DigitIdxWidth   = $clog2(BcdDigits);
  localparam int CountWidth      = 5;
  localparam int MaxDigitsDefault = 19;

  // Card class codes.
  localparam logic [1:0] ClassInvalid = 2'd0;
  localparam logic [1:0] ClassFifteen = 2'd1;
  localparam logic [1:0] ClassSixteen = 2'd2;
  localparam logic [1:0] ClassLeadFour = 2'd3;

  // Lengths and leading digits used by the classifier.
  localparam logic [CountWidth-1:0] LenThirteen = 5'd13;
  localparam logic [CountWidth-1:0] LenFifteen  = 5'd15;
  localparam logic [CountWidth-1:0] LenSixteen  = 5'd16;
  localparam logic [DigitWidth-1:0] DigitThree  = 4'd3;
  localparam logic [DigitWidth-1:0] DigitFour   = 4'd4;
  localparam logic [DigitWidth-1:0] DigitFive   = 4'd5;
  localparam logic [DigitWidth-1:0] DigitSeven  = 4'd7;
  localparam logic [DigitWidth-1:0] DigitOne    = 4'd1;

  // Double-dabble correction: add three to a BCD digit of five or more.
  function automatic logic [DigitWidth-1:0] adjust_digit(input logic [DigitWidth-1:0] d);
    return (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

  // Luhn contribution of one digit, doubled and digit-summed when requested.
  function automatic logic [DigitWidth-1:0] luhn_digit(input logic [DigitWidth-1:0] d,
                                                       input logic dbl);
    logic [DigitWidth:0] t;
    t = {d, 1'b0};
    if (!dbl) begin
      return d;
    end
    return (t >= 5'd10) ? DigitWidth'(t - 5'd9) : t[DigitWidth-1:0];
  endfunction

endpackage

@@ hw/rtl/lcc_bin2bcd.sv @@
// Iterative binary to BCD converter (shift and add-three), one bit per cycle.
// Depends on lcc_pkg.
module lcc_bin2bcd
  import lcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  done_o,
  output logic [BcdWidth-1:0]   bcd_o
);

  localparam int StepWidth = $clog2(ValueWidth);
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(ValueWidth - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [StepWidth-1:0]  step_q;
  logic [ValueWidth-1:0] bin_q;
  logic [BcdWidth-1:0]   bcd_q;
  logic [BcdWidth-1:0]   adj;

  // Correct every BCD digit before the shift; the digits are independent.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[i*DigitWidth +: DigitWidth] = adjust_digit(bcd_q[i*DigitWidth +: DigitWidth]);
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the binary value into the BCD register, most significant bit first.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[ValueWidth-2:0], 1'b0};
      bcd_q <= {adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ hw/rtl/luhn_card_number_classifier.sv @@
// Card number classifier: one card number in, one result transaction out. The
// number is first converted to decimal by a shift-and-add-three unit that takes
// one input bit per cycle, and the sequencer then loads the digits into a shift
// register. Then the 19 decimal digits are scanned from the least significant
// upward, one per cycle, forming the Luhn sum modulo ten, the digit count and
// the two leading digits. A final state classifies and loads the output
// register; a still-stalled earlier result holds this step back. in_stall_o is
// high from acceptance until then, so a new transaction is accepted only after
// the previous one has reached the output register. A new transaction is
// accepted while a finished result still waits at the output.
// Depends on lcc_pkg, lcc_bin2bcd and luhn_card_number_classifier_assert.svh.
`include "luhn_card_number_classifier_assert.svh"

module luhn_card_number_classifier
  import lcc_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ValueWidth-1:0] card_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  checksum_ok_o,
  output logic [CountWidth-1:0] digit_count_o,
  output logic [1:0]            card_class_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [DigitIdxWidth-1:0] LastIdx   = DigitIdxWidth'(BcdDigits - 1);
  localparam logic [CountWidth-1:0]    MaxCount  = CountWidth'(MAX_DIGITS);

  logic [1:0]               state_q;
  logic                     accept;
  logic                     conv_done;
  logic [BcdWidth-1:0]      conv_bcd;

  logic [BcdWidth-1:0]      bcd_sh_q;
  logic [DigitIdxWidth-1:0] idx_q;
  logic [DigitWidth-1:0]    sum_q;
  logic [CountWidth-1:0]    count_q;
  logic [DigitWidth-1:0]    hi_q;
  logic [DigitWidth-1:0]    lo_q;
  logic [DigitWidth-1:0]    prev_q;

  logic [DigitWidth-1:0]    cur_digit;
  logic [DigitWidth-1:0]    contrib;
  logic [DigitWidth:0]      sum_ext;
  logic [DigitWidth-1:0]    sum_d;

  logic                     res_ok;
  logic [CountWidth-1:0]    res_count;
  logic [1:0]               res_class;

  logic                     out_valid_q;
  logic                     checksum_ok_q;
  logic [CountWidth-1:0]    digit_count_q;
  logic [1:0]               card_class_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Decimal conversion unit.
  lcc_bin2bcd u_bin2bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (card_value_i),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // Luhn contribution of the current digit and the running sum modulo ten.
  always_comb begin
    cur_digit = bcd_sh_q[DigitWidth-1:0];
    contrib   = luhn_digit(cur_digit, idx_q[0]);
    sum_ext   = {1'b0, sum_q} + {1'b0, contrib};
    sum_d     = (sum_ext >= 5'd10) ? DigitWidth'(sum_ext - 5'd10) : sum_ext[DigitWidth-1:0];
  end

  // Classification from the scan results.
  always_comb begin
    res_ok    = (sum_q == '0);
    res_count = count_q;
    res_class = ClassInvalid;
    priority if (count_q > MaxCount) begin
      res_ok    = 1'b0;
      res_count = MaxCount;
    end else if (!res_ok) begin
      res_class = ClassInvalid;
    end else if (count_q == LenFifteen) begin
      if (hi_q == DigitThree && (lo_q == DigitFour || lo_q == DigitSeven)) begin
        res_class = ClassFifteen;
      end
    end else if (count_q == LenSixteen) begin
      if (hi_q == DigitFive && lo_q >= DigitOne && lo_q <= DigitFive) begin
        res_class = ClassSixteen;
      end else if (hi_q == DigitFour) begin
        res_class = ClassLeadFour;
      end
    end else if (count_q == LenThirteen) begin
      if (hi_q == DigitFour) begin
        res_class = ClassLeadFour;
      end
    end else begin
      res_class = ClassInvalid;
    end
  end

  // Sequencer, digit scan and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      prev_q      <= '0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            idx_q   <= '0;
            sum_q   <= '0;
            count_q <= '0;
            hi_q    <= '0;
            lo_q    <= '0;
            prev_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          sum_q  <= sum_d;
          prev_q <= cur_digit;
          if (cur_digit != '0) begin
            count_q <= CountWidth'(idx_q) + 1'b1;
            hi_q    <= cur_digit;
            lo_q    <= prev_q;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Digit shift register and result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CONV && conv_done) begin
      bcd_sh_q <= conv_bcd;
    end else if (state_q == S_SCAN) begin
      bcd_sh_q <= {{DigitWidth{1'b0}}, bcd_sh_q[BcdWidth-1:DigitWidth]};
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      checksum_ok_q <= res_ok;
      digit_count_q <= res_count;
      card_class_q  <= res_class;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign checksum_ok_o = checksum_ok_q;
  assign digit_count_o = digit_count_q;
  assign card_class_o  = card_class_q;

  // Checks on the sequencer and the result.
  `LCC_ASSERT(a_conv_done_in_conv, conv_done |-> state_q == S_CONV, "conversion ended outside CONV")
  `LCC_ASSERT(a_class_needs_ok, (out_valid_o && card_class_o != ClassInvalid) |-> checksum_ok_o, "class without passing check")
  `LCC_ASSERT(a_count_bounded, out_valid_o |-> digit_count_o <= MaxCount, "digit count above limit")
  `LCC_ASSERT_NEVER(a_scan_idx_range, state_q == S_SCAN && idx_q > LastIdx, "scan index out of range")

endmodule
